### src/les_pkg.sv
// les_pkg: widths, register indexes, reset values and arithmetic helpers
// for the lorenz euler stepper; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COUNT_WIDTH = 20;
    localparam int FRAC_BITS   = 24;
    localparam int MUL_WIDTH   = COORD_WIDTH + 1;
    localparam int DIV_WIDTH   = COUNT_WIDTH + 8;
    localparam int CFG_WIDTH   = 32;
    localparam int DT_WIDTH    = 24;
    localparam int INDEX_WIDTH = 3;
    localparam int SEGMENTS    = 6;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [MUL_WIDTH-1:0]   t_mop;
    typedef logic [COUNT_WIDTH-1:0]        t_count;
    typedef logic [DIV_WIDTH-1:0]          t_dword;
    typedef logic [23:0]                   t_rgb;

    localparam logic [INDEX_WIDTH-1:0] CFG_SIGMA = 3'd0;
    localparam logic [INDEX_WIDTH-1:0] CFG_RHO   = 3'd1;
    localparam logic [INDEX_WIDTH-1:0] CFG_BETA  = 3'd2;
    localparam logic [INDEX_WIDTH-1:0] CFG_DT    = 3'd3;
    localparam logic [INDEX_WIDTH-1:0] CFG_LIMIT = 3'd4;
    localparam logic [INDEX_WIDTH-1:0] CFG_W     = 3'd5;

    localparam logic [31:0]          SIGMA_RST = 32'd167772160;
    localparam logic [31:0]          RHO_RST   = 32'd469762048;
    localparam logic [31:0]          BETA_RST  = 32'd44738124;
    localparam logic [DT_WIDTH-1:0]  DT_RST    = 24'd16777;
    localparam logic [COUNT_WIDTH-1:0] LIMIT_RST = COUNT_WIDTH'(50000);
    localparam logic [31:0]          W_RST     = 32'd16777216;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord COORD_ONE = t_coord'(64'd1 << FRAC_BITS);

    // saturating a + b or a - b
    function automatic t_coord sat_add(input t_coord a, input t_coord b, input logic sub);
        logic signed [COORD_WIDTH:0] s;
        if (sub) begin
            s = (COORD_WIDTH+1)'(a) - (COORD_WIDTH+1)'(b);
        end else begin
            s = (COORD_WIDTH+1)'(a) + (COORD_WIDTH+1)'(b);
        end
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

    // 32-bit signed coefficient clamped into the coordinate range
    function automatic t_coord coeff_to_coord(input logic [31:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        if (w > 64'(COORD_MAX)) begin
            return COORD_MAX;
        end
        if (w < 64'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return t_coord'(w);
    endfunction

    function automatic t_mop to_mop(input t_coord v);
        return t_mop'(v);
    endfunction

    // rainbow ramp, 255 - v is the bitwise inverse of v
    function automatic t_rgb colour_of(input logic [2:0] seg, input logic [7:0] v);
        t_rgb c;
        unique case (seg)
            3'd0:    c = {8'hFF, v, 8'h00};
            3'd1:    c = {~v, 8'hFF, 8'h00};
            3'd2:    c = {8'h00, 8'hFF, v};
            3'd3:    c = {8'h00, ~v, 8'hFF};
            3'd4:    c = {v, 8'h00, 8'hFF};
            default: c = {8'hFF, 8'h00, ~v};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### src/lorenz_euler_stepper.sv
// lorenz_euler_stepper: top level, sequencer for one forward euler step and
// rainbow colour per request; uses les_pkg, les_ser_mul, les_ser_div
//
//   channel | signals                                   | direction
//   in      | i_in_valid, o_in_ready, i_restart         | request in
//   out     | o_out_valid, i_out_ready, point/colour     | result out
//   cfg     | i_cfg_we, i_cfg_index, i_cfg_data          | register write
//
// a stepping request takes 7 serial products, then up to
// 3 serial divides (limit/6, index/period, ramp) and one store step
// a request past the step limit is taken and gives no result
// reset is synchronous active low; no clearing pass
// a finished result waits in the output register while the next request
// is taken; only the final store waits for a stalled output
`timescale 1ns / 1ps
`default_nettype none

module lorenz_euler_stepper import les_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]   i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_restart,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_coord                      o_x_pos,
    output t_coord                      o_y_pos,
    output t_coord                      o_z_pos,
    output logic [31:0]                 o_w_out,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_blue,
    output t_count                      o_step_index,
    output logic                        o_last_step
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MGO   = 3'd1;
    localparam logic [2:0] S_MWAIT = 3'd2;
    localparam logic [2:0] S_DGO   = 3'd3;
    localparam logic [2:0] S_DWAIT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [2:0] OP_DX = 3'd0;
    localparam logic [2:0] OP_DY = 3'd1;
    localparam logic [2:0] OP_XY = 3'd2;
    localparam logic [2:0] OP_BZ = 3'd3;
    localparam logic [2:0] OP_UX = 3'd4;
    localparam logic [2:0] OP_UY = 3'd5;
    localparam logic [2:0] OP_UZ = 3'd6;

    localparam logic [1:0] DV_PER  = 2'd0;
    localparam logic [1:0] DV_SEG  = 2'd1;
    localparam logic [1:0] DV_RAMP = 2'd2;

    // configuration
    logic [31:0]          r_sigma, r_rho, r_beta, r_w;
    logic [DT_WIDTH-1:0]  r_dt;
    t_count               r_limit;

    // run state
    logic [2:0] r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [1:0] r_dop, n_dop;
    t_coord     r_x, r_y, r_z, n_x, n_y, n_z;
    t_coord     r_dx, r_dy, r_dz, n_dx, n_dy, n_dz;
    t_count     r_count, n_count;
    t_count     r_idx, n_idx;
    t_count     r_per, n_per;
    t_count     r_pos, n_pos;
    logic [2:0] r_seg, n_seg;
    t_rgb       r_held, n_held;
    t_rgb       r_col, n_col;

    // output register
    logic        r_out_valid, n_out_valid;
    t_coord      r_ox, r_oy, r_oz;
    logic [31:0] r_ow;
    t_rgb        r_ocol;
    t_count      r_oidx;
    logic        r_olast;
    logic        load_out;

    // serial units
    logic   mul_start, mul_done;
    t_mop   mul_a, mul_b;
    t_coord mul_res;
    logic   div_start, div_done;
    t_dword div_dividend, div_quo;
    t_count div_divisor, div_rem;

    t_coord sigma_c, rho_c, beta_c;
    t_count eff_count;
    logic   accept;

    les_ser_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    les_ser_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign sigma_c    = coeff_to_coord(r_sigma);
    assign rho_c      = coeff_to_coord(r_rho);
    assign beta_c     = coeff_to_coord(r_beta);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign mul_start  = (r_state == S_MGO);
    assign div_start  = (r_state == S_DGO);

    // operand select for the current product
    always_comb begin
        unique case (r_op)
            OP_DX: begin
                mul_a = to_mop(sigma_c);
                mul_b = to_mop(sat_add(r_y, r_x, 1'b1));
            end
            OP_DY: begin
                mul_a = to_mop(r_x);
                mul_b = to_mop(sat_add(rho_c, r_z, 1'b1));
            end
            OP_XY: begin
                mul_a = to_mop(r_x);
                mul_b = to_mop(r_y);
            end
            OP_BZ: begin
                mul_a = to_mop(beta_c);
                mul_b = to_mop(r_z);
            end
            OP_UX: begin
                mul_a = t_mop'({1'b0, r_dt});
                mul_b = to_mop(r_dx);
            end
            OP_UY: begin
                mul_a = t_mop'({1'b0, r_dt});
                mul_b = to_mop(r_dy);
            end
            default: begin
                mul_a = t_mop'({1'b0, r_dt});
                mul_b = to_mop(r_dz);
            end
        endcase
    end

    // operand select for the current divide
    always_comb begin
        unique case (r_dop)
            DV_PER: begin
                div_dividend = DIV_WIDTH'(r_limit);
                div_divisor  = COUNT_WIDTH'(SEGMENTS);
            end
            DV_SEG: begin
                div_dividend = DIV_WIDTH'(r_idx);
                div_divisor  = r_per;
            end
            default: begin
                div_dividend = (DIV_WIDTH'(r_pos) << 8) - DIV_WIDTH'(r_pos);
                div_divisor  = r_per;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_dop       = r_dop;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_dz        = r_dz;
        n_count     = r_count;
        n_idx       = r_idx;
        n_per       = r_per;
        n_pos       = r_pos;
        n_seg       = r_seg;
        n_held      = r_held;
        n_col       = r_col;
        load_out    = 1'b0;
        eff_count   = i_restart ? '0 : r_count;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_restart) begin
                        n_x     = COORD_ONE;
                        n_y     = COORD_ONE;
                        n_z     = COORD_ONE;
                        n_count = '0;
                        n_held  = '0;
                    end
                    if (eff_count < r_limit) begin
                        n_idx   = eff_count;
                        n_op    = OP_DX;
                        n_state = S_MGO;
                    end
                end
            end
            S_MGO: begin
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (mul_done) begin
                    unique case (r_op)
                        OP_DX:   n_dx = mul_res;
                        OP_DY:   n_dy = sat_add(mul_res, r_y, 1'b1);
                        OP_XY:   n_dz = mul_res;
                        OP_BZ:   n_dz = sat_add(r_dz, mul_res, 1'b1);
                        OP_UX:   n_x  = sat_add(r_x, mul_res, 1'b0);
                        OP_UY:   n_y  = sat_add(r_y, mul_res, 1'b0);
                        default: n_z  = sat_add(r_z, mul_res, 1'b0);
                    endcase
                    if (r_op == OP_UZ) begin
                        n_dop   = DV_PER;
                        n_state = S_DGO;
                    end else begin
                        n_op    = r_op + 1'b1;
                        n_state = S_MGO;
                    end
                end
            end
            S_DGO: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    unique case (r_dop)
                        DV_PER: begin
                            n_per = div_quo[COUNT_WIDTH-1:0];
                            if (div_quo == '0) begin
                                // limit under six: always black
                                n_col   = '0;
                                n_held  = '0;
                                n_state = S_OUT;
                            end else begin
                                n_dop   = DV_SEG;
                                n_state = S_DGO;
                            end
                        end
                        DV_SEG: begin
                            if (div_quo >= DIV_WIDTH'(SEGMENTS)) begin
                                n_col   = r_held;
                                n_state = S_OUT;
                            end else begin
                                n_seg   = div_quo[2:0];
                                n_pos   = div_rem;
                                n_dop   = DV_RAMP;
                                n_state = S_DGO;
                            end
                        end
                        default: begin
                            n_col   = colour_of(r_seg, div_quo[7:0]);
                            n_held  = colour_of(r_seg, div_quo[7:0]);
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_count     = r_idx + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma     <= SIGMA_RST;
            r_rho       <= RHO_RST;
            r_beta      <= BETA_RST;
            r_dt        <= DT_RST;
            r_limit     <= LIMIT_RST;
            r_w         <= W_RST;
            r_state     <= S_IDLE;
            r_op        <= OP_DX;
            r_dop       <= DV_PER;
            r_x         <= COORD_ONE;
            r_y         <= COORD_ONE;
            r_z         <= COORD_ONE;
            r_count     <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SIGMA: r_sigma <= i_cfg_data[31:0];
                    CFG_RHO:   r_rho   <= i_cfg_data[31:0];
                    CFG_BETA:  r_beta  <= i_cfg_data[31:0];
                    CFG_DT:    r_dt    <= i_cfg_data[DT_WIDTH-1:0];
                    CFG_LIMIT: r_limit <= i_cfg_data[COUNT_WIDTH-1:0];
                    CFG_W:     r_w     <= i_cfg_data[31:0];
                    default:   ;
                endcase
            end
            r_state     <= n_state;
            r_op        <= n_op;
            r_dop       <= n_dop;
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
            r_count     <= n_count;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_dz  <= n_dz;
        r_idx <= n_idx;
        r_per <= n_per;
        r_pos <= n_pos;
        r_seg <= n_seg;
        r_col <= n_col;
        if (load_out) begin
            r_ox    <= r_x;
            r_oy    <= r_y;
            r_oz    <= r_z;
            r_ow    <= r_w;
            r_ocol  <= r_col;
            r_oidx  <= r_idx;
            r_olast <= ((COUNT_WIDTH+1)'(r_idx) + 1'b1) == (COUNT_WIDTH+1)'(r_limit);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_x_pos      = r_ox;
    assign o_y_pos      = r_oy;
    assign o_z_pos      = r_oz;
    assign o_w_out      = r_ow;
    assign o_red        = r_ocol[23:16];
    assign o_green      = r_ocol[15:8];
    assign o_blue       = r_ocol[7:0];
    assign o_step_index = r_oidx;
    assign o_last_step  = r_olast;

endmodule

`default_nettype wire

### src/les_ser_mul.sv
// les_ser_mul: serial shift-add fixed-point multiplier, one multiplier bit
// per cycle, truncating q.24 product with saturation; uses les_pkg
`timescale 1ns / 1ps
`default_nettype none

module les_ser_mul import les_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_mop   i_a,
    input  wire t_mop   i_b,
    output logic        o_done,
    output t_coord      o_result
);

    localparam int CNT_W  = $clog2(MUL_WIDTH + 1);
    localparam int PROD_W = 2 * MUL_WIDTH;
    localparam int MAG_W  = PROD_W - FRAC_BITS;

    logic                 r_busy, r_fin, r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_neg;
    logic [MUL_WIDTH-1:0] r_mcand, r_hi, r_lo;
    t_coord               r_result;

    logic [MUL_WIDTH-1:0] mag_a, mag_b;
    logic [MUL_WIDTH:0]   sum;
    logic [PROD_W-1:0]    prod;
    logic [MAG_W-1:0]     mag;
    logic                 over;
    t_coord               res;

    always_comb begin
        mag_a = i_a[MUL_WIDTH-1] ? MUL_WIDTH'(-i_a) : MUL_WIDTH'(i_a);
        mag_b = i_b[MUL_WIDTH-1] ? MUL_WIDTH'(-i_b) : MUL_WIDTH'(i_b);
        sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(MUL_WIDTH+1){1'b0}});
        prod  = {r_hi, r_lo};
        mag   = prod[PROD_W-1:FRAC_BITS];
        over  = |mag[MAG_W-1:COORD_WIDTH-1];
        if (over) begin
            res = r_neg ? COORD_MIN : COORD_MAX;
        end else if (r_neg) begin
            res = t_coord'(-mag[COORD_WIDTH-1:0]);
        end else begin
            res = t_coord'(mag[COORD_WIDTH-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= mag_a;
            r_hi    <= '0;
            r_lo    <= mag_b;
            r_neg   <= i_a[MUL_WIDTH-1] ^ i_b[MUL_WIDTH-1];
        end else if (r_busy) begin
            r_hi <= sum[MUL_WIDTH:1];
            r_lo <= {sum[0], r_lo[MUL_WIDTH-1:1]};
        end
        if (r_fin) begin
            r_result <= res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

### src/les_ser_div.sv
// les_ser_div: restoring divider, one quotient bit per cycle
// uses les_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

module les_ser_div import les_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_dword i_dividend,
    input  wire t_count i_divisor,
    output logic        o_done,
    output t_dword      o_quotient,
    output t_count      o_remainder
);

    localparam int CNT_W = $clog2(DIV_WIDTH + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    t_dword           r_quo;
    t_count           r_rem, r_div;

    logic [COUNT_WIDTH:0] trial, diff;
    logic                 ge;

    always_comb begin
        trial = {r_rem, r_quo[DIV_WIDTH-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[DIV_WIDTH-2:0], ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

### test/tb_top.sv
// tb_top: self-checking bench for lorenz_euler_stepper, directed and random requests
// against an in-bench euler step and rainbow predictor, with random request gaps and
// output stalls; depends on les_pkg and the stepper rtl
`timescale 1ns / 1ps

module tb_top;
    import les_pkg::*;

    localparam int ITEMS         = 1200;
    localparam int SETTLE_CYCLES = 500;
    localparam int CYCLE_LIMIT   = 6000000;
    localparam int PRINT_CAP     = 50;

    localparam logic [INDEX_WIDTH-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [INDEX_WIDTH-1:0] CFG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {OP_TICK, OP_CFG, OP_SETTLE, OP_IDLE} t_stim_kind;

    typedef struct packed {
        t_stim_kind              kind;
        logic                    flag;
        logic [INDEX_WIDTH-1:0]  index;
        logic [CFG_WIDTH-1:0]    data;
    } t_stim_op;

    typedef struct packed {
        t_coord      x;
        t_coord      y;
        t_coord      z;
        logic [31:0] w;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        t_count      idx;
        logic        last;
    } t_step_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we    = 1'b0;
    logic [INDEX_WIDTH-1:0] i_cfg_index = CFG_SIGMA;
    logic [CFG_WIDTH-1:0]   i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic                   i_restart   = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_coord                 o_x_pos;
    t_coord                 o_y_pos;
    t_coord                 o_z_pos;
    logic [31:0]            o_w_out;
    logic [7:0]             o_red;
    logic [7:0]             o_green;
    logic [7:0]             o_blue;
    t_count                 o_step_index;
    logic                   o_last_step;

    lorenz_euler_stepper u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_x_pos      (o_x_pos),
        .o_y_pos      (o_y_pos),
        .o_z_pos      (o_z_pos),
        .o_w_out      (o_w_out),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_step_index (o_step_index),
        .o_last_step  (o_last_step)
    );

    t_stim_op     stim_q[$];
    t_step_result pending_points[$];

    int   err_count    = 0;
    int   results_done = 0;
    int   cycle_count  = 0;
    int   gap_left     = 0;
    int   settle_left  = 0;
    int   stall_left   = 0;
    logic idle_on      = 1'b1;

    // predictor state and register copies
    t_coord      orbit_x, orbit_y, orbit_z;
    t_count      orbit_step;
    t_rgb        held_rgb;
    logic [31:0] reg_sigma, reg_rho, reg_beta, reg_w;
    logic [23:0] reg_dt;
    t_count      reg_limit;

    function automatic longint clamp_coord(input longint v);
        if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
        if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
        return v;
    endfunction

    // q.24 product truncated toward zero
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> FRAC_BITS;
        return clamp_coord((p < 0) ? -m : m);
    endfunction

    function automatic void restart_orbit();
        orbit_x    = COORD_ONE;
        orbit_y    = COORD_ONE;
        orbit_z    = COORD_ONE;
        orbit_step = '0;
        held_rgb   = '0;
    endfunction

    function automatic void reset_predictor();
        reg_sigma = SIGMA_RST;
        reg_rho   = RHO_RST;
        reg_beta  = BETA_RST;
        reg_dt    = DT_RST;
        reg_limit = LIMIT_RST;
        reg_w     = W_RST;
        restart_orbit();
    endfunction

    function automatic void write_register(input logic [INDEX_WIDTH-1:0] idx,
                                           input logic [CFG_WIDTH-1:0] data);
        case (idx)
            CFG_SIGMA: reg_sigma = data;
            CFG_RHO:   reg_rho   = data;
            CFG_BETA:  reg_beta  = data;
            CFG_DT:    reg_dt    = data[DT_WIDTH-1:0];
            CFG_LIMIT: reg_limit = data[COUNT_WIDTH-1:0];
            CFG_W:     reg_w     = data;
            default: ;
        endcase
    endfunction

    function automatic t_rgb rainbow_for(input t_count idx, input t_count lim);
        int unsigned per, seg, pos, lvl;
        logic [7:0]  v;
        per = lim / SEGMENTS;
        if (per == 0) begin
            held_rgb = '0;
            return '0;
        end
        seg = idx / per;
        if (seg >= SEGMENTS) return held_rgb;
        pos = idx % per;
        lvl = (pos * 255) / per;
        v   = lvl[7:0];
        case (seg)
            0:       held_rgb = {8'd255, v, 8'd0};
            1:       held_rgb = {8'd255 - v, 8'd255, 8'd0};
            2:       held_rgb = {8'd0, 8'd255, v};
            3:       held_rgb = {8'd0, 8'd255 - v, 8'd255};
            4:       held_rgb = {v, 8'd0, 8'd255};
            default: held_rgb = {8'd255, 8'd0, 8'd255 - v};
        endcase
        return held_rgb;
    endfunction

    function automatic logic advance_attractor(input logic restart, output t_step_result res);
        longint sg, rh, bt, dt, x, y, z, dx, dy, dz;
        t_rgb   rgb;
        res = '0;
        if (restart) restart_orbit();
        if (orbit_step >= reg_limit) return 1'b0;
        sg = longint'(signed'(reg_sigma));
        rh = longint'(signed'(reg_rho));
        bt = longint'(signed'(reg_beta));
        dt = longint'(reg_dt);
        x  = longint'(orbit_x);
        y  = longint'(orbit_y);
        z  = longint'(orbit_z);
        dx = qmul(sg, clamp_coord(y - x));
        dy = clamp_coord(qmul(x, clamp_coord(rh - z)) - y);
        dz = clamp_coord(qmul(x, y) - qmul(bt, z));
        orbit_x = t_coord'(clamp_coord(x + qmul(dt, dx)));
        orbit_y = t_coord'(clamp_coord(y + qmul(dt, dy)));
        orbit_z = t_coord'(clamp_coord(z + qmul(dt, dz)));
        rgb = rainbow_for(orbit_step, reg_limit);
        res.x     = orbit_x;
        res.y     = orbit_y;
        res.z     = orbit_z;
        res.w     = reg_w;
        res.red   = rgb[23:16];
        res.green = rgb[15:8];
        res.blue  = rgb[7:0];
        res.idx   = orbit_step;
        res.last  = (32'(orbit_step) + 1) == 32'(reg_limit);
        orbit_step = orbit_step + 1'b1;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input t_count idx);
        if (got !== want) begin
            flag_mismatch($sformatf("step %0d %s got %h expected %h", idx, name, got, want));
        end
    endtask

    task automatic push_tick(input logic restart);
        stim_q.push_back('{kind: OP_TICK, flag: restart, index: '0, data: '0});
    endtask

    task automatic push_cfg(input logic [INDEX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
        stim_q.push_back('{kind: OP_CFG, flag: 1'b0, index: idx, data: data});
    endtask

    task automatic push_settle();
        stim_q.push_back('{kind: OP_SETTLE, flag: 1'b0, index: '0, data: '0});
    endtask

    task automatic push_idle(input logic on);
        stim_q.push_back('{kind: OP_IDLE, flag: on, index: '0, data: '0});
    endtask

    function automatic logic [31:0] pick_coeff(input logic [31:0] nominal);
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return $urandom;
            default: return nominal + $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_dt();
        logic [7:0] junk;
        junk = $urandom;
        case ($urandom_range(0, 5))
            0:       return {junk, 24'h0};
            1:       return {junk, 24'hFF_FFFF};
            2:       return {junk, 24'($urandom_range(0, 32'h0010_0000))};
            default: return {junk, 24'($urandom_range(1000, 50000))};
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        logic [11:0] junk;
        junk = $urandom;
        case ($urandom_range(0, 9))
            0:       return {junk, 20'($urandom_range(0, 5))};
            1:       return {junk, 20'hF_FFFF};
            2:       return {junk, LIMIT_RST};
            3:       return {junk, 20'($urandom_range(61, 200))};
            default: return {junk, 20'($urandom_range(6, 60))};
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // request driver
    always @(posedge i_clk) begin : drive_requests
        t_stim_op     op;
        t_step_result res;
        logic         valid_n;
        logic         we_n;
        valid_n = i_in_valid;
        we_n    = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (advance_attractor(i_restart, res)) pending_points.push_back(res);
                valid_n = 1'b0;
                if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 15);
            end
            if (!valid_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (settle_left > 0) begin
                    settle_left--;
                end else if (stim_q.size() > 0) begin
                    op = stim_q[0];
                    case (op.kind)
                        OP_TICK: begin
                            valid_n = 1'b1;
                            i_restart <= op.flag;
                            void'(stim_q.pop_front());
                        end
                        OP_CFG: begin
                            we_n = 1'b1;
                            i_cfg_index <= op.index;
                            i_cfg_data  <= op.data;
                            write_register(op.index, op.data);
                            void'(stim_q.pop_front());
                        end
                        OP_SETTLE: begin
                            if (pending_points.size() == 0) begin
                                settle_left = SETTLE_CYCLES;
                                void'(stim_q.pop_front());
                            end
                        end
                        default: begin
                            idle_on <= op.flag;
                            void'(stim_q.pop_front());
                        end
                    endcase
                end
            end
        end
        i_in_valid <= valid_n;
        i_cfg_we   <= we_n;
    end

    // result monitor
    always @(posedge i_clk) begin : watch_results
        t_step_result want;
        logic         ready_n;
        ready_n = i_out_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_points.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result, step %0d", o_step_index));
                end else begin
                    want = pending_points.pop_front();
                    check_field("x_pos", o_x_pos, want.x, want.idx);
                    check_field("y_pos", o_y_pos, want.y, want.idx);
                    check_field("z_pos", o_z_pos, want.z, want.idx);
                    check_field("w_out", o_w_out, want.w, want.idx);
                    check_field("red", 32'(o_red), 32'(want.red), want.idx);
                    check_field("green", 32'(o_green), 32'(want.green), want.idx);
                    check_field("blue", 32'(o_blue), 32'(want.blue), want.idx);
                    check_field("step_index", 32'(o_step_index), 32'(want.idx), want.idx);
                    check_field("last_step", 32'(o_last_step), 32'(want.last), want.idx);
                    results_done++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                ready_n = 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(0, 14);
                ready_n = 1'b0;
            end else begin
                ready_n = 1'b1;
            end
        end
        i_out_ready <= ready_n;
    end

    initial begin : run_test
        int   n;
        int   lim_hint;
        logic calm_tail;
        logic [31:0] lim_word;
        i_rst_n     = 1'b0;
        calm_tail   = 1'b0;
        reset_predictor();

        // reset values, then restart
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b1);
        // saturating coefficients, short run past the last segment and past the limit
        push_settle();
        push_cfg(CFG_SIGMA, 32'h7FFF_FFFF);
        push_cfg(CFG_RHO, 32'h8000_0000);
        push_cfg(CFG_BETA, 32'h8000_0000);
        push_cfg(CFG_DT, 32'hFFFF_FFFF);
        push_cfg(CFG_W, 32'h8000_0000);
        push_cfg(CFG_LIMIT, 32'd14);
        push_tick(1'b1);
        for (int k = 0; k < 14; k++) push_tick(1'b0);
        // limit under six gives black
        push_settle();
        push_cfg(CFG_SIGMA, 32'h8000_0000);
        push_cfg(CFG_RHO, 32'h7FFF_FFFF);
        push_cfg(CFG_BETA, 32'h7FFF_FFFF);
        push_cfg(CFG_DT, 32'h0);
        push_cfg(CFG_W, 32'h7FFF_FFFF);
        push_cfg(CFG_SPARE_A, 32'hFFFF_FFFF);
        push_cfg(CFG_SPARE_B, 32'h5A5A_A5A5);
        push_cfg(CFG_LIMIT, 32'd3);
        push_tick(1'b1);
        for (int k = 0; k < 3; k++) push_tick(1'b0);
        // zero limit, nothing comes back
        push_settle();
        push_cfg(CFG_LIMIT, 32'h0);
        push_tick(1'b1);
        lim_hint = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (results_done < ITEMS) begin
            while (stim_q.size() != 0) @(posedge i_clk);
            if (results_done >= ITEMS - 150) calm_tail = 1'b1;
            push_settle();
            push_idle(calm_tail ? 1'b0 : ($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 1) == 0) push_cfg(CFG_SIGMA, pick_coeff(SIGMA_RST));
            if ($urandom_range(0, 1) == 0) push_cfg(CFG_RHO, pick_coeff(RHO_RST));
            if ($urandom_range(0, 1) == 0) push_cfg(CFG_BETA, pick_coeff(BETA_RST));
            if ($urandom_range(0, 1) == 0) push_cfg(CFG_W, $urandom);
            if ($urandom_range(0, 2) == 0) push_cfg(CFG_DT, pick_dt());
            if (lim_hint == 0 || $urandom_range(0, 1) == 0) begin
                lim_word = pick_limit();
                lim_hint = int'(lim_word[COUNT_WIDTH-1:0]);
                push_cfg(CFG_LIMIT, lim_word);
            end
            if ($urandom_range(0, 7) == 0) begin
                push_cfg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
            end
            n = $urandom_range(1, (lim_hint + 2 > 70) ? 70 : lim_hint + 2);
            for (int k = 0; k < n; k++) begin
                if (k == 0) begin
                    push_tick($urandom_range(0, 3) != 0);
                end else begin
                    push_tick($urandom_range(0, 24) == 0);
                end
                // hold requests until every result is back
                if (k == n / 2 && $urandom_range(0, 5) == 0) push_settle();
            end
        end

        while (stim_q.size() != 0 || i_in_valid || pending_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_points.size() != 0) begin
            flag_mismatch($sformatf("%0d expected results never arrived", pending_points.size()));
        end
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
